// ===== rtl/sbrs_pkg.sv =====
// ----------------------------------------------------------------------------
// sbrs_pkg
// Shared widths, constants and types for the swept box slab test.
// ----------------------------------------------------------------------------
package sbrs_pkg;

   localparam int COORD_FRAC_BITS = 8;
   localparam int TIME_FRAC_BITS  = 16;

   localparam int COORD_W = 24;
   localparam int SIZE_W  = 22;
   localparam int DELTA_W = COORD_W + 2;
   localparam int MAG_W   = DELTA_W - 1;
   localparam int NUM_W   = MAG_W + TIME_FRAC_BITS;
   localparam int DEN_W   = COORD_W;
   localparam int TIME_W  = 32;
   localparam int QUO_W   = TIME_W - 1;
   localparam int PROD_W  = COORD_W + TIME_W;
   localparam int SUM_W   = PROD_W + 4;

   localparam int IN_DATA_W  = 232;
   localparam int OUT_DATA_W = 136;

   localparam logic signed [TIME_W-1:0] TIME_MAX = {1'b0, {(TIME_W-1){1'b1}}};
   localparam logic signed [TIME_W-1:0] TIME_MIN = {1'b1, {(TIME_W-1){1'b0}}};
   localparam logic signed [TIME_W-1:0] TIME_ONE = TIME_W'(1) <<< TIME_FRAC_BITS;

   localparam logic [2:0] NORMAL_NONE  = 3'd0;
   localparam logic [2:0] NORMAL_POS_X = 3'd1;
   localparam logic [2:0] NORMAL_NEG_X = 3'd2;
   localparam logic [2:0] NORMAL_POS_Y = 3'd3;
   localparam logic [2:0] NORMAL_NEG_Y = 3'd4;

   typedef struct packed {
      logic [3:0]                 neg;
      logic [3:0]                 sat;
      logic                       bad;
      logic signed [COORD_W-1:0]  vel_x;
      logic signed [COORD_W-1:0]  vel_y;
      logic signed [DELTA_W-1:0]  org2_x;
      logic signed [DELTA_W-1:0]  org2_y;
   } side_type;

endpackage

// ===== rtl/sbrs_div.sv =====
// ----------------------------------------------------------------------------
// sbrs_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module sbrs_div
   import sbrs_pkg::*;
(
   input  logic             clock,
   input  logic             advance,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [QUO_W-1:0] quo
);

   localparam int CMP_W = DEN_W + QUO_W;

   logic [NUM_W-1:0] rem_ff [QUO_W];
   logic [DEN_W-1:0] den_ff [QUO_W];
   logic [QUO_W-1:0] quo_ff [QUO_W];

   for (genvar k = 0; k < QUO_W; k++) begin : g_stage
      logic [NUM_W-1:0] rem_src;
      logic [DEN_W-1:0] den_src;
      logic [QUO_W-1:0] quo_src;
      logic [CMP_W-1:0] shifted;
      logic [CMP_W-1:0] diff;
      logic             take;

      if (k == 0) begin : g_first
         assign rem_src = num;
         assign den_src = den;
         assign quo_src = '0;
      end else begin : g_next
         assign rem_src = rem_ff[k-1];
         assign den_src = den_ff[k-1];
         assign quo_src = quo_ff[k-1];
      end

      assign shifted = CMP_W'(den_src) << (QUO_W - 1 - k);
      assign take    = CMP_W'(rem_src) >= shifted;
      assign diff    = CMP_W'(rem_src) - shifted;

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k] <= take ? diff[NUM_W-1:0] : rem_src;
            den_ff[k] <= den_src;
            quo_ff[k] <= quo_src | (QUO_W'(take) << (QUO_W - 1 - k));
         end
      end
   end

   assign quo = quo_ff[QUO_W-1];

endmodule

// ===== rtl/sbrs_point.sv =====
// ----------------------------------------------------------------------------
// sbrs_point
// Point along the ray: origin + velocity * time, rounded and saturated.
// ----------------------------------------------------------------------------
module sbrs_point
   import sbrs_pkg::*;
(
   input  logic                      clock,
   input  logic                      advance,
   input  logic signed [DELTA_W-1:0] org2,
   input  logic signed [COORD_W-1:0] vel,
   input  logic signed [TIME_W-1:0]  tim,
   input  logic                      keep,
   output logic signed [COORD_W-1:0] point
);

   localparam logic signed [SUM_W-1:0] C_MAX = SUM_W'((64'sd1 <<< (COORD_W - 1)) - 1);
   localparam logic signed [SUM_W-1:0] C_MIN = -(SUM_W'(64'sd1 <<< (COORD_W - 1)));

   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [DELTA_W-1:0] org_ff;
   logic signed [COORD_W-1:0] point_ff;
   logic signed [SUM_W-1:0]   sum;
   logic signed [SUM_W-1:0]   shifted;
   logic signed [COORD_W-1:0] point_in;

   always_comb begin
      sum     = (SUM_W'(org_ff) <<< TIME_FRAC_BITS) + (SUM_W'(prod_ff) <<< 1)
                + (SUM_W'(1) <<< TIME_FRAC_BITS);
      shifted = sum >>> (TIME_FRAC_BITS + 1);
      if (shifted > C_MAX) begin
         point_in = C_MAX[COORD_W-1:0];
      end else if (shifted < C_MIN) begin
         point_in = C_MIN[COORD_W-1:0];
      end else begin
         point_in = shifted[COORD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff  <= PROD_W'(vel) * PROD_W'(tim);
         org_ff   <= org2;
         point_ff <= keep ? point_in : '0;
      end
   end

   assign point = point_ff;

endmodule

// ===== rtl/swept_box_ray_slab_test.sv =====
// ----------------------------------------------------------------------------
// swept_box_ray_slab_test
// Swept box against static box: slab test with entry and exit points.
// ----------------------------------------------------------------------------
// Fully pipelined: one transaction per cycle. From request accept to result
// valid it passes two setup stages, 31 divider stages, time fixup, sort, slab
// compare, multiply and round. The four entry/exit divisions run
// in parallel dividers that retire one quotient bit per stage. The whole pipe
// advances together; it halts only while a result sits unaccepted.
module swept_box_ray_slab_test
   import sbrs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // source_x, source_y, source_width, source_height, velocity_x, velocity_y,
   // target_x, target_y, target_width, target_height
   input  logic [IN_DATA_W-1:0]  req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // hit, line_crosses, near_time, near_x, near_y, far_x, far_y, normal, pad
   output logic [OUT_DATA_W-1:0] rsp_tdata
);

   localparam int SIDE_DEPTH = QUO_W;

   logic advance;

   logic signed [COORD_W-1:0] source_x, source_y, velocity_x, velocity_y;
   logic signed [COORD_W-1:0] target_x, target_y;
   logic [SIZE_W-1:0]         source_width, source_height, target_width, target_height;

   assign source_x      = req_tdata[23:0];
   assign source_y      = req_tdata[47:24];
   assign source_width  = req_tdata[69:48];
   assign source_height = req_tdata[91:70];
   assign velocity_x    = req_tdata[115:92];
   assign velocity_y    = req_tdata[139:116];
   assign target_x      = req_tdata[163:140];
   assign target_y      = req_tdata[187:164];
   assign target_width  = req_tdata[209:188];
   assign target_height = req_tdata[231:210];

   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   // stage 1: deltas
   logic                      v1_ff;
   logic signed [DELTA_W-1:0] delta_ff [4];
   logic signed [COORD_W-1:0] vx1_ff, vy1_ff;
   logic signed [DELTA_W-1:0] ox1_ff, oy1_ff;
   logic signed [DELTA_W-1:0] sw_ext, sh_ext, tw_ext, th_ext;

   assign sw_ext = DELTA_W'($signed({1'b0, source_width}));
   assign sh_ext = DELTA_W'($signed({1'b0, source_height}));
   assign tw_ext = DELTA_W'($signed({1'b0, target_width}));
   assign th_ext = DELTA_W'($signed({1'b0, target_height}));

   always_ff @(posedge clock) begin
      if (advance) begin
         delta_ff[0] <= DELTA_W'(target_x) - DELTA_W'(source_x) - sw_ext;
         delta_ff[1] <= DELTA_W'(target_x) + tw_ext - DELTA_W'(source_x);
         delta_ff[2] <= DELTA_W'(target_y) - DELTA_W'(source_y) - sh_ext;
         delta_ff[3] <= DELTA_W'(target_y) + th_ext - DELTA_W'(source_y);
         vx1_ff      <= velocity_x;
         vy1_ff      <= velocity_y;
         ox1_ff      <= (DELTA_W'(source_x) <<< 1) + sw_ext;
         oy1_ff      <= (DELTA_W'(source_y) <<< 1) + sh_ext;
      end
   end

   // stage 2: magnitudes and saturation flags
   logic                 v2_ff;
   logic [NUM_W-1:0]     num_ff [4];
   logic [DEN_W-1:0]     den_x_ff, den_y_ff;
   side_type             side2_ff;
   logic [NUM_W-1:0]     num_in [4];
   logic [DEN_W-1:0]     den_x_in, den_y_in;
   side_type             side2_in;

   always_comb begin
      logic signed [DELTA_W-1:0] dabs;
      logic signed [COORD_W-1:0] vel;
      logic [DEN_W-1:0]          den;
      logic                      vzero;
      den_x_in = vx1_ff[COORD_W-1] ? DEN_W'(-vx1_ff) : DEN_W'(vx1_ff);
      den_y_in = vy1_ff[COORD_W-1] ? DEN_W'(-vy1_ff) : DEN_W'(vy1_ff);
      side2_in.bad    = 1'b0;
      side2_in.vel_x  = vx1_ff;
      side2_in.vel_y  = vy1_ff;
      side2_in.org2_x = ox1_ff;
      side2_in.org2_y = oy1_ff;
      for (int i = 0; i < 4; i++) begin
         vel   = (i < 2) ? vx1_ff : vy1_ff;
         den   = (i < 2) ? den_x_in : den_y_in;
         vzero = (vel == '0);
         dabs  = delta_ff[i][DELTA_W-1] ? -delta_ff[i] : delta_ff[i];
         num_in[i] = {dabs[MAG_W-1:0], {TIME_FRAC_BITS{1'b0}}};
         side2_in.neg[i] = delta_ff[i][DELTA_W-1] ^ vel[COORD_W-1];
         side2_in.sat[i] = vzero ||
            ((DEN_W + QUO_W + 1)'(num_in[i]) >= ((DEN_W + QUO_W + 1)'(den) << QUO_W));
         if (vzero && delta_ff[i] == '0) begin
            side2_in.bad = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 4; i++) begin
            num_ff[i] <= num_in[i];
         end
         den_x_ff <= den_x_in;
         den_y_ff <= den_y_in;
         side2_ff <= side2_in;
      end
   end

   // divider stages
   logic [QUO_W-1:0] quo [4];

   for (genvar i = 0; i < 4; i++) begin : g_div
      sbrs_div u_div (
         .clock   (clock),
         .advance (advance),
         .num     (num_ff[i]),
         .den     ((i < 2) ? den_x_ff : den_y_ff),
         .quo     (quo[i])
      );
   end

   side_type side_ff [SIDE_DEPTH];
   logic     vd_ff   [SIDE_DEPTH];

   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0] <= side2_ff;
         for (int k = 1; k < SIDE_DEPTH; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // stage 3: signed, saturated times
   logic                      v3_ff;
   logic signed [TIME_W-1:0]  t3_ff [4];
   side_type                  side3_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 4; i++) begin
            if (side_ff[SIDE_DEPTH-1].sat[i]) begin
               t3_ff[i] <= side_ff[SIDE_DEPTH-1].neg[i] ? TIME_MIN : TIME_MAX;
            end else if (side_ff[SIDE_DEPTH-1].neg[i]) begin
               t3_ff[i] <= -$signed({1'b0, quo[i]});
            end else begin
               t3_ff[i] <= $signed({1'b0, quo[i]});
            end
         end
         side3_ff <= side_ff[SIDE_DEPTH-1];
      end
   end

   // stage 4: per-axis sort
   logic                     v4_ff;
   logic signed [TIME_W-1:0] nx4_ff, fx4_ff, ny4_ff, fy4_ff;
   side_type                 side4_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         nx4_ff   <= (t3_ff[0] > t3_ff[1]) ? t3_ff[1] : t3_ff[0];
         fx4_ff   <= (t3_ff[0] > t3_ff[1]) ? t3_ff[0] : t3_ff[1];
         ny4_ff   <= (t3_ff[2] > t3_ff[3]) ? t3_ff[3] : t3_ff[2];
         fy4_ff   <= (t3_ff[2] > t3_ff[3]) ? t3_ff[2] : t3_ff[3];
         side4_ff <= side3_ff;
      end
   end

   // stage 5: slab overlap, near and far times
   logic                     v5_ff;
   logic                     cross5_ff, xgt5_ff, xlt5_ff;
   logic signed [TIME_W-1:0] tn5_ff, tf5_ff;
   side_type                 side5_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         cross5_ff <= !side4_ff.bad && (nx4_ff < fy4_ff) && (ny4_ff < fx4_ff);
         xgt5_ff   <= nx4_ff > ny4_ff;
         xlt5_ff   <= nx4_ff < ny4_ff;
         tn5_ff    <= (nx4_ff > ny4_ff) ? nx4_ff : ny4_ff;
         tf5_ff    <= (fx4_ff < fy4_ff) ? fx4_ff : fy4_ff;
         side5_ff  <= side4_ff;
      end
   end

   // stage 6: hit and face normal; products inside the point units
   logic                     v6_ff;
   logic                     hit6_ff, cross6_ff;
   logic [2:0]               normal6_ff;
   logic [2:0]               normal_in;
   logic                     hit_in;
   logic signed [TIME_W-1:0] tn6_ff;

   always_comb begin
      hit_in    = cross5_ff && (tf5_ff >= 0) && (tn5_ff <= TIME_ONE);
      normal_in = NORMAL_NONE;
      if (hit_in) begin
         if (xgt5_ff) begin
            normal_in = side5_ff.vel_x[COORD_W-1] ? NORMAL_POS_X : NORMAL_NEG_X;
         end else if (xlt5_ff) begin
            normal_in = side5_ff.vel_y[COORD_W-1] ? NORMAL_POS_Y : NORMAL_NEG_Y;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         hit6_ff    <= hit_in;
         cross6_ff  <= cross5_ff;
         normal6_ff <= normal_in;
         tn6_ff     <= tn5_ff;
      end
   end

   logic signed [COORD_W-1:0] near_x, near_y, far_x, far_y;

   sbrs_point u_near_x (
      .clock (clock), .advance (advance), .org2 (side5_ff.org2_x),
      .vel (side5_ff.vel_x), .tim (tn5_ff), .keep (cross6_ff), .point (near_x));
   sbrs_point u_near_y (
      .clock (clock), .advance (advance), .org2 (side5_ff.org2_y),
      .vel (side5_ff.vel_y), .tim (tn5_ff), .keep (cross6_ff), .point (near_y));
   sbrs_point u_far_x (
      .clock (clock), .advance (advance), .org2 (side5_ff.org2_x),
      .vel (side5_ff.vel_x), .tim (tf5_ff), .keep (cross6_ff), .point (far_x));
   sbrs_point u_far_y (
      .clock (clock), .advance (advance), .org2 (side5_ff.org2_y),
      .vel (side5_ff.vel_y), .tim (tf5_ff), .keep (cross6_ff), .point (far_y));

   // stage 7: output register
   logic                     rsp_valid_ff;
   logic                     hit_ff, cross_ff;
   logic [2:0]               normal_ff;
   logic signed [TIME_W-1:0] near_time_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         hit_ff       <= hit6_ff;
         cross_ff     <= cross6_ff;
         normal_ff    <= normal6_ff;
         near_time_ff <= cross6_ff ? tn6_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < SIDE_DEPTH; k++) begin
            vd_ff[k] <= 1'b0;
         end
      end else if (advance) begin
         v1_ff    <= req_tvalid;
         v2_ff    <= v1_ff;
         vd_ff[0] <= v2_ff;
         for (int k = 1; k < SIDE_DEPTH; k++) begin
            vd_ff[k] <= vd_ff[k-1];
         end
         v3_ff        <= vd_ff[SIDE_DEPTH-1];
         v4_ff        <= v3_ff;
         v5_ff        <= v4_ff;
         v6_ff        <= v5_ff;
         rsp_valid_ff <= v6_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, normal_ff, far_y, far_x, near_y, near_x,
                        near_time_ff, cross_ff, hit_ff};

endmodule

// ===== rtl/sbrs_checker.sv =====
// ----------------------------------------------------------------------------
// sbrs_checker
// Port-level checks for the swept box slab test, bound to the top level.
// ----------------------------------------------------------------------------
module sbrs_checker
   import sbrs_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [OUT_DATA_W-1:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_ready_flow: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("request ready not tied to output flow");

   a_hit_cross: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!rsp_tdata[0] || rsp_tdata[1]) &&
                     (rsp_tdata[132:130] == NORMAL_NONE || rsp_tdata[0]))
      else $error("hit or normal without crossing");

   a_no_cross_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[1] |-> rsp_tdata[129:2] == '0)
      else $error("nonzero fields without crossing");

endmodule

bind swept_box_ray_slab_test sbrs_checker u_sbrs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for swept_box_ray_slab_test. Box pairs stream in on
// the req channel; an in-bench slab predictor computes the expected result
// of every accepted transaction, and each rsp transaction is checked field
// by field against the oldest prediction. Directed corner cases come first,
// then random traffic under three idle/stall profiles.
// ----------------------------------------------------------------------------
module tb_top;
   import sbrs_pkg::*;

   typedef struct packed {
      logic [SIZE_W-1:0]         target_height;
      logic [SIZE_W-1:0]         target_width;
      logic signed [COORD_W-1:0] target_y;
      logic signed [COORD_W-1:0] target_x;
      logic signed [COORD_W-1:0] velocity_y;
      logic signed [COORD_W-1:0] velocity_x;
      logic [SIZE_W-1:0]         source_height;
      logic [SIZE_W-1:0]         source_width;
      logic signed [COORD_W-1:0] source_y;
      logic signed [COORD_W-1:0] source_x;
   } box_pair_type;

   typedef struct packed {
      logic [2:0]                pad;
      logic [2:0]                normal;
      logic signed [COORD_W-1:0] far_y;
      logic signed [COORD_W-1:0] far_x;
      logic signed [COORD_W-1:0] near_y;
      logic signed [COORD_W-1:0] near_x;
      logic signed [TIME_W-1:0]  near_time;
      logic                      line_crosses;
      logic                      hit;
   } contact_type;

   localparam int STALL_LIMIT = 5000;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [IN_DATA_W-1:0]  req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [OUT_DATA_W-1:0] rsp_tdata;

   contact_type expected_contacts[$];
   int          error_count;
   int          sent_count;
   int          hit_count;
   int          cross_count;
   int          quiet_cycles;
   int          idle_pct;
   int          stall_pct;

   swept_box_ray_slab_test dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic longint span_time(longint delta, longint vel, inout bit ok);
      longint q;
      if (vel == 0) begin
         if (delta > 0) return 64'sd2147483647;
         if (delta < 0) return -64'sd2147483648;
         ok = 1'b0;
         return 0;
      end
      q = (delta * 65536) / vel;
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      if (q < -64'sd2147483648) q = -64'sd2147483648;
      return q;
   endfunction

   function automatic logic [COORD_W-1:0] point_at_time(longint org2, longint vel,
                                                         longint t);
      longint num;
      num = org2 * 65536 + 2 * vel * t + 65536;
      num = num >>> (TIME_FRAC_BITS + 1);
      if (num > 64'sd8388607) num = 64'sd8388607;
      if (num < -64'sd8388608) num = -64'sd8388608;
      return num[COORD_W-1:0];
   endfunction

   function automatic contact_type predict_contact(box_pair_type b);
      contact_type r;
      bit          ok;
      longint      sx, sy, sw, sh, vx, vy, tx, ty, tw, th;
      longint      nx, fx, ny, fy, tn, tf, s;
      sx = b.source_x;  sy = b.source_y;
      sw = b.source_width;  sh = b.source_height;
      vx = b.velocity_x;  vy = b.velocity_y;
      tx = b.target_x;  ty = b.target_y;
      tw = b.target_width;  th = b.target_height;
      r  = '0;
      ok = 1'b1;
      nx = span_time(tx - sx - sw, vx, ok);
      fx = span_time(tx + tw - sx, vx, ok);
      ny = span_time(ty - sy - sh, vy, ok);
      fy = span_time(ty + th - sy, vy, ok);
      if (nx > fx) begin s = nx; nx = fx; fx = s; end
      if (ny > fy) begin s = ny; ny = fy; fy = s; end
      if (ok && nx < fy && ny < fx) begin
         tn = (nx > ny) ? nx : ny;
         tf = (fx < fy) ? fx : fy;
         r.line_crosses = 1'b1;
         r.near_time    = tn[TIME_W-1:0];
         r.near_x       = point_at_time(2 * sx + sw, vx, tn);
         r.near_y       = point_at_time(2 * sy + sh, vy, tn);
         r.far_x        = point_at_time(2 * sx + sw, vx, tf);
         r.far_y        = point_at_time(2 * sy + sh, vy, tf);
         if (tf >= 0 && tn <= 65536) begin
            r.hit = 1'b1;
            if (nx > ny) r.normal = (vx < 0) ? NORMAL_POS_X : NORMAL_NEG_X;
            else if (nx < ny) r.normal = (vy < 0) ? NORMAL_POS_Y : NORMAL_NEG_Y;
            else r.normal = NORMAL_NONE;
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(string field, longint want, longint got);
      $display("mismatch %s: expected %0d got %0d (time %0t)", field, want, got, $time);
      error_count++;
   endtask

   // result checker
   always @(posedge clock) begin
      contact_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_contacts.size() == 0) begin
            $display("unexpected rsp transaction (time %0t)", $time);
            error_count++;
         end else begin
            want = expected_contacts.pop_front();
            if (got.hit != want.hit) report_mismatch("hit", want.hit, got.hit);
            if (got.line_crosses != want.line_crosses)
               report_mismatch("line_crosses", want.line_crosses, got.line_crosses);
            if (got.near_time != want.near_time)
               report_mismatch("near_time", want.near_time, got.near_time);
            if (got.near_x != want.near_x) report_mismatch("near_x", want.near_x, got.near_x);
            if (got.near_y != want.near_y) report_mismatch("near_y", want.near_y, got.near_y);
            if (got.far_x != want.far_x) report_mismatch("far_x", want.far_x, got.far_x);
            if (got.far_y != want.far_y) report_mismatch("far_y", want.far_y, got.far_y);
            if (got.normal != want.normal) report_mismatch("normal", want.normal, got.normal);
         end
      end
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout after %0d quiet cycles", quiet_cycles);
         $display("tb_top: done, errors");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic send_box(box_pair_type b);
      contact_type r;
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      r = predict_contact(b);
      expected_contacts.push_back(r);
      sent_count++;
      hit_count   += r.hit;
      cross_count += r.line_crosses;
      @(negedge clock);
   endtask

   function automatic box_pair_type make_box(longint sx, longint sy, longint sw,
                                             longint sh, longint vx, longint vy,
                                             longint tx, longint ty, longint tw,
                                             longint th);
      box_pair_type b;
      b.source_x = COORD_W'(sx);  b.source_y = COORD_W'(sy);
      b.source_width = SIZE_W'(sw);  b.source_height = SIZE_W'(sh);
      b.velocity_x = COORD_W'(vx);  b.velocity_y = COORD_W'(vy);
      b.target_x = COORD_W'(tx);  b.target_y = COORD_W'(ty);
      b.target_width = SIZE_W'(tw);  b.target_height = SIZE_W'(th);
      return b;
   endfunction

   function automatic longint rand_signed(int span);
      return longint'($urandom_range(2 * span)) - span;
   endfunction

   function automatic longint rand_size(int span);
      return longint'($urandom_range(span));
   endfunction

   task automatic test_corner_cases();
      // ray head-on along +x, and along -x
      send_box(make_box(0, 0, 0, 0, 25600, 0, 12800, -256, 2560, 512));
      send_box(make_box(20000, 0, 0, 0, -25600, 0, 12800, -256, 2560, 512));
      // box moving +y and -y
      send_box(make_box(0, 0, 512, 512, 0, 9000, -256, 3000, 1024, 1024));
      send_box(make_box(0, 9000, 512, 512, 0, -9000, -256, 3000, 1024, 1024));
      // zero velocity on one axis, outside on that axis
      send_box(make_box(0, 0, 256, 256, 5000, 0, 2000, 4000, 512, 512));
      // zero velocity with zero delta on an axis
      send_box(make_box(0, 0, 256, 256, 5000, 0, 256, 256, 512, 512));
      // no motion inside the grown box
      send_box(make_box(100, 100, 256, 256, 0, 0, 0, 0, 1024, 1024));
      // diagonal tie of near times
      send_box(make_box(0, 0, 0, 0, 2560, 2560, 1280, 1280, 2560, 2560));
      // miss, and a box behind the ray
      send_box(make_box(0, 0, 0, 0, 2560, 0, 1280, 5000, 256, 256));
      send_box(make_box(0, 0, 0, 0, 2560, 0, -5000, -256, 512, 512));
      // too far for this step
      send_box(make_box(0, 0, 0, 0, 256, 0, 100000, -256, 512, 512));
      // field extremes and saturation
      send_box(make_box(8388607, 8388607, 4194303, 4194303, 8388607, 8388607,
                        8388607, 8388607, 4194303, 4194303));
      send_box(make_box(-8388608, -8388608, 0, 0, -8388608, -8388608,
                        -8388608, -8388608, 0, 0));
      send_box(make_box(-8388608, -8388608, 4194303, 4194303, 1, 1,
                        8388607, 8388607, 4194303, 4194303));
      send_box(make_box(8388607, -8388608, 4194303, 0, -1, 8388607,
                        -8388608, 8388607, 0, 4194303));
      send_box(make_box(0, 0, 4194303, 4194303, 0, 0, -8388608, -8388608,
                        4194303, 4194303));
   endtask

   task automatic test_random_traffic(int count);
      box_pair_type b;
      int           kind;
      repeat (count) begin
         kind = $urandom_range(99);
         if (kind < 15) begin
            b = IN_DATA_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom});
         end else begin
            b = make_box(rand_signed(8000), rand_signed(8000), rand_size(2000),
                         rand_size(2000), rand_signed(12000), rand_signed(12000),
                         rand_signed(8000), rand_signed(8000), rand_size(4000),
                         rand_size(4000));
            if (kind < 25) b.velocity_x = '0;
            else if (kind < 35) b.velocity_y = '0;
            else if (kind < 40) begin
               b.velocity_x = '0;
               b.velocity_y = '0;
            end else if (kind < 45) b.source_width = '0;
            if (kind >= 45 && kind < 50) b.velocity_y = b.velocity_x;
         end
         send_box(b);
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      rsp_tready  = 1'b0;
      idle_pct    = 30;
      stall_pct   = 55;
      error_count = 0;
      sent_count  = 0;
      hit_count   = 0;
      cross_count = 0;
      quiet_cycles = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_corner_cases();
      test_random_traffic(540);
      idle_pct  = 55;
      stall_pct = 30;
      test_random_traffic(540);
      idle_pct  = 0;
      stall_pct = 0;
      test_random_traffic(540);
      req_tvalid <= 1'b0;

      while (expected_contacts.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);

      $display("covered %0d box pairs: %0d line crossings, %0d hits in step",
               sent_count, cross_count, hit_count);
      $display("mismatches: %0d", error_count);
      if (error_count == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule
